// ===== sv/pitch_complementary_filter_top_assert.svh =====
// Assertion macros used by the pitch filter top
`ifndef PITCH_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define PITCH_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define PCF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pcf_pkg.sv =====
`default_nettype none
package pcf_pkg;

   localparam int SQRT_STEPS = 24;
   localparam int SQRT_CNT_W = 5;
   localparam int DIV_STEPS  = 60;
   localparam int DIV_CNT_W  = 6;
   localparam int CORD_W     = 28;

   localparam logic [1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [1:0] CSR_ALPHA     = 2'd1;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [19:0] gyro_rate;
      logic        [31:0] tick_now;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pitch;
      logic               reloaded;
   } rsp_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic signed [31:0] atan_q16(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sd2949120;
         5'd1:  v = 32'sd1740967;
         5'd2:  v = 32'sd919879;
         5'd3:  v = 32'sd466945;
         5'd4:  v = 32'sd234379;
         5'd5:  v = 32'sd117304;
         5'd6:  v = 32'sd58666;
         5'd7:  v = 32'sd29335;
         5'd8:  v = 32'sd14668;
         5'd9:  v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/pcf_isqrt.sv =====
`default_nettype none
module pcf_isqrt
   import pcf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] radicand,
   output logic             busy,
   output logic [23:0]      root
);

   logic [47:0]           rad_ff, rad_in;
   logic [24:0]           rem_ff, rem_in;
   logic [23:0]           root_ff, root_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [26:0]           rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[47:46]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[45:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 25'(rem_sh - trial);
            root_in = {root_ff[22:0], 1'b1};
         end else begin
            rem_in  = rem_sh[24:0];
            root_in = {root_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== sv/pcf_cordic.sv =====
`default_nettype none
module pcf_cordic
   import pcf_pkg::*;
#(
   parameter int ITERATIONS = 16
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [23:0]        x0,
   input  wire logic signed [23:0] y0,
   output logic                    busy,
   output logic signed [31:0]      angle
);

   localparam int CW = $clog2(ITERATIONS + 1);

   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [31:0]       z_ff, z_in, step_angle;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;

   always_comb begin
      xs         = x_ff >>> cnt_ff;
      ys         = y_ff >>> cnt_ff;
      step_angle = atan_q16(5'(cnt_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = CORD_W'($signed({1'b0, x0}));
         y_in    = CORD_W'(y0);
         z_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // y exactly zero leaves the vector alone
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle;
         end else if (y_ff < 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ITERATIONS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy  = busy_ff;
   assign angle = z_ff;

endmodule
`default_nettype wire

// ===== sv/pcf_divider.sv =====
`default_nettype none
module pcf_divider
   import pcf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [59:0] dividend,
   input  wire logic [16:0] divisor,
   output logic             busy,
   output logic [59:0]      quotient
);

   logic [59:0]          quo_ff, quo_in;
   logic [16:0]          rem_ff, rem_in, div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [17:0]          rem_sh;

   // restoring division, one quotient bit a cycle; quo_ff doubles as dividend shifter
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[59]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = 17'(rem_sh - {1'b0, div_ff});
            quo_in = {quo_ff[58:0], 1'b1};
         end else begin
            rem_in = rem_sh[16:0];
            quo_in = {quo_ff[58:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== sv/pitch_complementary_filter_top.sv =====
// Complementary-filter pitch estimator. One transaction on req_ carries three
// accelerometer axes, a gyro rate and a tick stamp; one rsp_ transaction returns
// the fused pitch in Q16 degrees and a flag set when the pitch was reloaded from
// the accelerometer. The 60-step radix-2 divider scales the gyro increment by the
// tick rate; the square root (24 steps) and then the CORDIC (CORDIC_ITERATIONS
// steps) run alongside it. A new item is taken only once the previous result
// has gone into the rsp_ register, later if that is held up by rsp_ready.
// req_ready is low while an item is in work. csr_ writes are always taken:
// index 0 tick rate, index 1 alpha; other indexes are ignored.
`default_nettype none
module pitch_complementary_filter_top
   import pcf_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_wdata
);

`include "pitch_complementary_filter_top_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_START, S_RUN, S_SUM, S_MUL, S_ADD, S_OUT
   } state_type;

   state_type state_ff;

   req_type            in_ff;
   logic [31:0]        last_tick_ff, elapsed_ff, sq_ff;
   logic signed [31:0] pitch_acc_ff, result_ff;
   logic [16:0]        rate_ff, alpha_ff;
   logic               reload_ff, cord_started_ff;
   logic [51:0]        mag_ff;
   logic signed [34:0] hi_ff;
   logic [15:0]        lo_ff;
   logic [32:0]        p1_ff;
   logic signed [49:0] p2_ff;
   logic signed [52:0] p3_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               req_fire, rsp_load, sqrt_start, div_start, cord_start;
   logic               sqrt_busy, div_busy, cord_busy;
   logic [23:0]        root;
   logic [59:0]        quotient, dividend;
   logic signed [31:0] angle;
   logic [16:0]        rate_eff, alpha_sat, beta;
   logic [19:0]        g_abs;
   logic signed [31:0] sqy, sqz;
   logic signed [60:0] delta;
   logic signed [61:0] sum;
   logic signed [45:0] hi_full;
   logic signed [34:0] hi_clamp;
   logic signed [53:0] part;
   logic signed [54:0] total;
   logic signed [31:0] total_sat;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign sqrt_start = (state_ff == S_START);
   assign div_start  = (state_ff == S_START);
   assign cord_start = (state_ff == S_RUN) && !sqrt_busy && !cord_started_ff;

   always_comb begin
      rate_eff  = (rate_ff == '0) ? 17'd1 : rate_ff;
      alpha_sat = (alpha_ff > 17'd65536) ? 17'd65536 : alpha_ff;
      beta      = 17'(18'd65536 - {1'b0, alpha_sat});
      g_abs     = in_ff.gyro_rate[19] ? 20'(~in_ff.gyro_rate + 1'b1) : in_ff.gyro_rate;
      sqy       = in_ff.accel_y * in_ff.accel_y;
      sqz       = in_ff.accel_z * in_ff.accel_z;
      dividend  = {mag_ff, 8'd0} + 60'(rate_eff >> 1);
      delta     = in_ff.gyro_rate[19] ? -$signed({1'b0, quotient})
                                      : $signed({1'b0, quotient});
      sum       = 62'(pitch_acc_ff) + 62'(delta);
      hi_full   = sum[61:16];
      // beyond this range the blend saturates whatever alpha is, unless alpha is zero
      if (hi_full[45:34] == {12{hi_full[45]}})
         hi_clamp = hi_full[34:0];
      else if (hi_full[45])
         hi_clamp = {1'b1, 34'd0};
      else
         hi_clamp = {1'b0, {34{1'b1}}};
      part  = (54'($signed({1'b0, p1_ff})) + 54'(p2_ff) + 54'sd32768) >>> 16;
      total = 55'(p3_ff) + 55'(part);
      if (total > 55'sd2147483647)
         total_sat = 32'h7fff_ffff;
      else if (total < -55'sd2147483648)
         total_sat = 32'h8000_0000;
      else
         total_sat = total[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         last_tick_ff    <= '0;
         pitch_acc_ff    <= '0;
         rate_ff         <= 17'd100;
         alpha_ff        <= 17'd64225;
         rsp_valid_ff    <= 1'b0;
         cord_started_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TICK_RATE: rate_ff  <= csr_wdata;
               CSR_ALPHA:     alpha_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  in_ff        <= req_data;
                  elapsed_ff   <= req_data.tick_now - last_tick_ff;
                  reload_ff    <= (last_tick_ff == '0) || (req_data.tick_now == last_tick_ff);
                  last_tick_ff <= req_data.tick_now;
                  state_ff     <= S_PREP;
               end
            end
            S_PREP: begin
               mag_ff   <= g_abs * elapsed_ff;
               sq_ff    <= 32'(unsigned'(sqy)) + 32'(unsigned'(sqz));
               state_ff <= S_START;
            end
            S_START: begin
               cord_started_ff <= 1'b0;
               state_ff        <= S_RUN;
            end
            S_RUN: begin
               if (cord_start) cord_started_ff <= 1'b1;
               if (cord_started_ff && !cord_busy && !div_busy) state_ff <= S_SUM;
            end
            S_SUM: begin
               hi_ff <= hi_clamp;
               lo_ff <= sum[15:0];
               if (reload_ff) begin
                  result_ff <= angle;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               p1_ff    <= alpha_sat * lo_ff;
               p2_ff    <= $signed({1'b0, beta}) * angle;
               p3_ff    <= $signed({1'b0, alpha_sat}) * hi_ff;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               result_ff <= total_sat;
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_ff.pitch    <= result_ff;
                  rsp_ff.reloaded <= reload_ff;
                  pitch_acc_ff    <= result_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   pcf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({sq_ff, 16'd0}),
      .busy     (sqrt_busy),
      .root     (root)
   );

   pcf_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .x0    (root),
      .y0    ({in_ff.accel_x, 8'd0}),
      .busy  (cord_busy),
      .angle (angle)
   );

   pcf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (rate_eff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PCF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "ready after accept")
   `PCF_ASSERT_NOW(a_rsp_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `PCF_ASSERT_NOW(a_cordic_after_sqrt, clock, reset, cord_start, !sqrt_busy && !cord_busy, "cordic start early")
   `PCF_ASSERT_NOW(a_units_idle, clock, reset, state_ff == S_SUM, !div_busy && !cord_busy, "units busy at blend")

endmodule
`default_nettype wire
